// ===== hw/rtl/pswp_pkg.sv =====
// Shared types, codes and frame builder for the PLL serial word programmer.
// Used by the sequencer, the shift unit and the top level; no dependencies.
`default_nettype none

package pswp_pkg;

    // Shift unit sizes: longest frame is the programmable word with group code
    localparam int unsigned FRAME_W = 19;
    localparam int unsigned LEN_W   = 5;

    // Data bit counts of each word, strobes excluded
    localparam logic [LEN_W-1:0] OPT_LEN        = 5'd13;
    localparam logic [LEN_W-1:0] REF_LEN        = 5'd14;
    localparam logic [LEN_W-1:0] PRG_LEN_NO_GRP = 5'd17;
    localparam logic [LEN_W-1:0] PRG_LEN        = 5'd19;

    // Request commands
    localparam logic [1:0] CMD_OPTION    = 2'd0;
    localparam logic [1:0] CMD_REFERENCE = 2'd1;
    localparam logic [1:0] CMD_PROGRAM   = 2'd2;
    localparam logic [1:0] CMD_ALL       = 2'd3;

    // Channel select code that sends no group bits
    localparam logic [1:0] CH_NONE = 2'd0;

    // Output stream widths
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 8;

    // Event kinds carried on tuser
    localparam logic EV_DATA   = 1'b0;
    localparam logic EV_STROBE = 1'b1;

    typedef enum logic [1:0] {
        WORD_OPT = 2'd0,
        WORD_REF = 2'd1,
        WORD_PRG = 2'd2
    } t_word;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] reference_count;
        logic [4:0]  swallow_count;
        logic [11:0] program_count;
        logic [1:0]  channel_select;
        logic [1:0]  pump_tx;
        logic [1:0]  pump_rx;
        logic [1:0]  lock_mode;
        logic        standby_tx;
        logic        standby_rx;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] data;
        logic [LEN_W-1:0]   len;
    } t_frame;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

    typedef struct packed {
        logic bit_out;
        logic last_bit;
        logic empty;
    } t_shift_stat;

    // Lay out the data bits of one word, first bit sent in bit 0
    function automatic t_frame build_frame(input t_word word, input t_req req);
        t_frame f;
        f.data = '0;
        f.len  = '0;
        case (word)
            WORD_OPT: begin
                f.data[4:3]   = req.pump_tx;
                f.data[6:5]   = req.pump_rx;
                f.data[8:7]   = req.lock_mode;
                f.data[9]     = req.standby_tx;
                f.data[10]    = req.standby_rx;
                f.len         = OPT_LEN;
            end
            WORD_REF: begin
                f.data[11:0]  = req.reference_count;
                f.data[13:12] = 2'b11;
                f.len         = REF_LEN;
            end
            WORD_PRG: begin
                f.data[4:0]   = req.swallow_count;
                f.data[16:5]  = req.program_count;
                f.data[18:17] = req.channel_select;
                f.len         = (req.channel_select == CH_NONE) ? PRG_LEN_NO_GRP : PRG_LEN;
            end
            default: begin
                f.data = '0;
                f.len  = '0;
            end
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pll_serial_word_programmer.sv =====
// PLL serial word programmer: one request in, a stream of pin events out.
// The option word opens with a leading strobe; every word is then loaded,
// sent as one event per bit and closed by a strobe. The shift unit gives one
// bit per cycle while the output register is not stalled.
// Next request is taken once the last event sits in the output register.
// Synchronous active-low reset empties the output and returns to idle.
`default_nettype none

module pll_serial_word_programmer
    import pswp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // command[1:0], reference_count[13:2], swallow_count[18:14],
    // program_count[30:19], channel_select[32:31], pump_tx[34:33],
    // pump_rx[36:35], lock_mode[38:37], standby_tx[39], standby_rx[40], zeros
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // data_bit[0], zeros
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // event_kind[0]
    output logic                       o_m_tuser,
    // last
    output logic                       o_m_tlast
);

    t_req        req;
    t_shift_ctrl ctrl;
    t_shift_stat stat;
    t_frame      frame;
    logic        ev_bit;

    // Unpack the request fields
    assign req.command         = i_s_tdata[1:0];
    assign req.reference_count = i_s_tdata[13:2];
    assign req.swallow_count   = i_s_tdata[18:14];
    assign req.program_count   = i_s_tdata[30:19];
    assign req.channel_select  = i_s_tdata[32:31];
    assign req.pump_tx         = i_s_tdata[34:33];
    assign req.pump_rx         = i_s_tdata[36:35];
    assign req.lock_mode       = i_s_tdata[38:37];
    assign req.standby_tx      = i_s_tdata[39];
    assign req.standby_rx      = i_s_tdata[40];

    pswp_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .i_stat      (stat),
        .o_ctrl      (ctrl),
        .o_frame     (frame),
        .o_ev_valid  (o_m_tvalid),
        .i_ev_ready  (i_m_tready),
        .o_ev_kind   (o_m_tuser),
        .o_ev_bit    (ev_bit),
        .o_ev_last   (o_m_tlast)
    );

    pswp_shifter u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_frame (frame),
        .o_stat  (stat)
    );

    // Pack the data bit, zero fill
    assign o_m_tdata = {{(OUT_DATA_W-1){1'b0}}, ev_bit};

endmodule

`default_nettype wire

// ===== hw/rtl/pswp_shifter.sv =====
// Shared serializer: loads one word frame and shifts it out one bit a cycle while shift is asserted.
// Depends on pswp_pkg for the frame and control types.
`default_nettype none

module pswp_shifter
    import pswp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_shift_ctrl i_ctrl,
    input  wire t_frame      i_frame,
    output t_shift_stat      o_stat
);

    logic [FRAME_W-1:0] r_data;
    logic [LEN_W-1:0]   r_left;

    // Load a new frame or advance one bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_ctrl.load) begin
            r_data <= i_frame.data;
            r_left <= i_frame.len;
        end else if (i_ctrl.shift && (r_left != '0)) begin
            r_data <= r_data >> 1;
            r_left <= r_left - LEN_W'(1);
        end
    end

    assign o_stat.bit_out  = r_data[0];
    assign o_stat.last_bit = (r_left == LEN_W'(1));
    assign o_stat.empty    = (r_left == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/pswp_sequencer.sv =====
// Word sequencer: steps through strobes and frames of a request and drives
// the registered event output. Depends on pswp_pkg; controls pswp_shifter.
`default_nettype none

module pswp_sequencer
    import pswp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire t_req        i_req,
    input  wire t_shift_stat i_stat,
    output t_shift_ctrl      o_ctrl,
    output t_frame           o_frame,
    output logic             o_ev_valid,
    input  wire logic        i_ev_ready,
    output logic             o_ev_kind,
    output logic             o_ev_bit,
    output logic             o_ev_last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LEAD   = 5'b00010,
        S_LOAD   = 5'b00100,
        S_BITS   = 5'b01000,
        S_STROBE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_word  r_word,  n_word;
    t_req   r_req,   n_req;
    logic   r_out_valid, n_out_valid;
    logic   r_out_kind,  n_out_kind;
    logic   r_out_bit,   n_out_bit;
    logic   r_out_last,  n_out_last;

    logic adv;
    logic final_word;

    // Output slot is free when empty or being taken this cycle
    assign adv        = !r_out_valid || i_ev_ready;
    assign final_word = (r_req.command != CMD_ALL) || (r_word == WORD_PRG);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_frame     = build_frame(r_word, r_req);

    // Sequence strobes and frame bits
    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_ev_ready;
        n_out_kind  = r_out_kind;
        n_out_bit   = r_out_bit;
        n_out_last  = r_out_last;
        o_ctrl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    unique case (i_req.command) inside
                        CMD_OPTION, CMD_ALL: begin
                            n_word  = WORD_OPT;
                            n_state = S_LEAD;
                        end
                        CMD_REFERENCE: begin
                            n_word  = WORD_REF;
                            n_state = S_LOAD;
                        end
                        default: begin
                            n_word  = WORD_PRG;
                            n_state = S_LOAD;
                        end
                    endcase
                end
            end
            S_LEAD: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = EV_STROBE;
                    n_out_bit   = 1'b0;
                    n_out_last  = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_ctrl.load = 1'b1;
                n_state     = S_BITS;
            end
            S_BITS: begin
                if (adv) begin
                    o_ctrl.shift = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_kind   = EV_DATA;
                    n_out_bit    = i_stat.bit_out;
                    n_out_last   = 1'b0;
                    if (i_stat.last_bit) begin
                        n_state = S_STROBE;
                    end
                end
            end
            S_STROBE: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = EV_STROBE;
                    n_out_bit   = 1'b0;
                    n_out_last  = final_word;
                    if (final_word) begin
                        n_state = S_IDLE;
                    end else begin
                        n_word  = (r_word == WORD_OPT) ? WORD_REF : WORD_PRG;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word      <= WORD_OPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
        r_req      <= n_req;
        r_out_kind <= n_out_kind;
        r_out_bit  <= n_out_bit;
        r_out_last <= n_out_last;
    end

    assign o_ev_valid = r_out_valid;
    assign o_ev_kind  = r_out_kind;
    assign o_ev_bit   = r_out_bit;
    assign o_ev_last  = r_out_last;

    // Shifting never runs on an empty frame
    a_bits_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BITS) |-> !i_stat.empty)
        else $error("shift state with empty frame");

    // An accepted request starts with a strobe or a frame load
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> ((r_state == S_LEAD) || (r_state == S_LOAD)))
        else $error("request accepted without starting");

    // The final event of a request is always a strobe
    a_last_is_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_kind == EV_STROBE))
        else $error("last event is not a strobe");

    // A closing strobe that is not final moves on to the next frame
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STROBE) && adv && !final_word) |=> (r_state == S_LOAD))
        else $error("next word not loaded");

endmodule

`default_nettype wire
